>>> rtl/hctbp_pkg.sv
// Shared types and constants for the Huffman code table and bit packer.
package hctbp_pkg;

  localparam int SYMBOL_COUNT = 256;
  localparam int SYM_W        = 8;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int MAX_CODE_LEN = 32;
  localparam int LEN_LIMIT    = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int BYTE_W       = 8;
  localparam int RES_W        = 3;
  localparam int RES_MAX_W    = 7;
  localparam int ACC_W        = CODE_W + RES_MAX_W;
  localparam int TOT_W        = 6;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_W      = 2;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_ENCODE = 2'd1,
    KIND_FLUSH  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [SYM_W-1:0]   symbol;
    logic [CODE_W-1:0]  code_bits;
    logic [LEN_W-1:0]   code_length;
  } in_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0] packed_byte;
    logic              last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic              flush;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

>>> rtl/hctbp_ram.sv
// Generic single write port, single read port RAM with registered read.
module hctbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/hctbp_front.sv
// Front end: accepts transactions, owns the code table, issues pack commands.
module hctbp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  hctbp_pkg::in_item_t in_item,
  output logic                in_full,
  output logic                q_push,
  output hctbp_pkg::cmd_t     q_cmd,
  input  logic                q_full
);

  logic                                accept;
  logic                                is_load;
  logic                                is_work;
  logic [hctbp_pkg::LEN_W-1:0]         len_sat;
  hctbp_pkg::entry_t                   wr_entry;
  hctbp_pkg::entry_t                   rd_entry;
  logic [hctbp_pkg::SYMBOL_COUNT-1:0]  valid_r;
  logic                                s1_valid_r;
  logic                                s1_flush_r;
  logic                                s1_hit_r;
  logic [hctbp_pkg::LEN_W-1:0]         s1_len;
  logic [hctbp_pkg::CODE_W-1:0]        s1_mask;
  logic                                s1_want;

  assign accept  = in_push && !in_full;
  assign is_load = (in_item.kind == hctbp_pkg::KIND_LOAD);
  assign is_work = (in_item.kind == hctbp_pkg::KIND_ENCODE) ||
                   (in_item.kind == hctbp_pkg::KIND_FLUSH);

  assign len_sat = (in_item.code_length > hctbp_pkg::LEN_W'(hctbp_pkg::LEN_LIMIT)) ?
                   hctbp_pkg::LEN_W'(hctbp_pkg::LEN_LIMIT) : in_item.code_length;

  assign wr_entry.code = in_item.code_bits;
  assign wr_entry.len  = len_sat;

  hctbp_ram #(
    .WIDTH (hctbp_pkg::ENTRY_W),
    .DEPTH (hctbp_pkg::SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (accept && is_load),
    .waddr (in_item.symbol),
    .wdata (wr_entry),
    .re    (accept && (in_item.kind == hctbp_pkg::KIND_ENCODE)),
    .raddr (in_item.symbol),
    .rdata (rd_entry)
  );

  // entries never loaded read as zero length
  assign s1_len  = s1_hit_r ? rd_entry.len : '0;
  assign s1_mask = ~({hctbp_pkg::CODE_W{1'b1}} << s1_len);
  assign s1_want = s1_valid_r && (s1_flush_r || (s1_len != '0));
  assign in_full = s1_want && q_full;
  assign q_push  = s1_want && !q_full;

  assign q_cmd.flush = s1_flush_r;
  assign q_cmd.code  = s1_flush_r ? '0 : (rd_entry.code & s1_mask);
  assign q_cmd.len   = s1_flush_r ? '0 : s1_len;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept && is_load) begin
        valid_r[in_item.symbol] <= 1'b1;
      end
      if (!in_full) begin
        s1_valid_r <= accept && is_work;
      end
    end
    if (accept) begin
      s1_flush_r <= (in_item.kind == hctbp_pkg::KIND_FLUSH);
      s1_hit_r   <= valid_r[in_item.symbol];
    end
  end

endmodule

>>> rtl/hctbp_fifo.sv
// Short command queue between front end and packer.
module hctbp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  hctbp_pkg::cmd_t din,
  output logic            full,
  input  logic            pop,
  output hctbp_pkg::cmd_t dout,
  output logic            empty
);

  hctbp_pkg::cmd_t                 mem_r [hctbp_pkg::Q_DEPTH];
  logic [hctbp_pkg::Q_PTR_W-1:0]   wr_ptr_r;
  logic [hctbp_pkg::Q_PTR_W-1:0]   rd_ptr_r;
  logic [hctbp_pkg::Q_PTR_W:0]     count_r;

  assign full  = (count_r == (hctbp_pkg::Q_PTR_W+1)'(hctbp_pkg::Q_DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> rtl/hctbp_back.sv
// Packer: bit accumulator, byte extraction and output register.
module hctbp_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hctbp_pkg::cmd_t      q_cmd,
  input  logic                 q_empty,
  output logic                 q_pop,
  output hctbp_pkg::out_item_t out_item,
  output logic                 out_empty,
  input  logic                 out_pop
);

  logic [hctbp_pkg::ACC_W-1:0]      acc_r;
  logic [hctbp_pkg::ACC_W-1:0]      acc_nxt;
  logic [hctbp_pkg::TOT_W-1:0]      total_r;
  logic [hctbp_pkg::TOT_W-1:0]      total_nxt;
  logic                             ob_valid_r;
  hctbp_pkg::out_item_t             ob_item_r;
  logic                             out_ready;
  logic                             have_byte;
  logic                             emit;
  logic [hctbp_pkg::TOT_W-1:0]      rest_total;
  logic                             rest_small;
  logic [hctbp_pkg::ACC_W-1:0]      byte_sh;
  logic [hctbp_pkg::RES_W-1:0]      res_cnt;
  logic [hctbp_pkg::RES_MAX_W-1:0]  res_bits;
  logic [hctbp_pkg::BYTE_W-1:0]     pad;

  assign out_ready  = !ob_valid_r || out_pop;
  assign have_byte  = (total_r >= hctbp_pkg::TOT_W'(hctbp_pkg::BYTE_W));
  assign emit       = have_byte && out_ready;
  assign rest_total = total_r - hctbp_pkg::TOT_W'(hctbp_pkg::BYTE_W);
  assign rest_small = (rest_total < hctbp_pkg::TOT_W'(hctbp_pkg::BYTE_W));
  assign byte_sh    = acc_r >> rest_total;

  // next command may load while the last byte of the current one goes out
  assign q_pop = !q_empty && (!have_byte || (emit && rest_small));

  assign res_cnt  = have_byte ? rest_total[hctbp_pkg::RES_W-1:0] :
                                total_r[hctbp_pkg::RES_W-1:0];
  assign res_bits = acc_r[hctbp_pkg::RES_MAX_W-1:0] &
                    ~({hctbp_pkg::RES_MAX_W{1'b1}} << res_cnt);
  assign pad      = {1'b0, res_bits} << (4'd8 - {1'b0, res_cnt});

  always_comb begin
    acc_nxt   = acc_r;
    total_nxt = total_r;
    if (q_pop) begin
      if (q_cmd.flush) begin
        acc_nxt   = hctbp_pkg::ACC_W'(pad);
        total_nxt = (res_cnt != '0) ? hctbp_pkg::TOT_W'(hctbp_pkg::BYTE_W) : '0;
      end else begin
        acc_nxt   = (hctbp_pkg::ACC_W'(res_bits) << q_cmd.len) |
                    hctbp_pkg::ACC_W'(q_cmd.code);
        total_nxt = hctbp_pkg::TOT_W'(res_cnt) + q_cmd.len;
      end
    end else if (emit) begin
      total_nxt = rest_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      total_r    <= '0;
      ob_valid_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      total_r <= total_nxt;
      if (out_ready) begin
        ob_valid_r <= emit;
      end
    end
    if (emit) begin
      ob_item_r.packed_byte <= byte_sh[hctbp_pkg::BYTE_W-1:0];
      ob_item_r.last_of_run <= rest_small;
    end
  end

  assign out_item  = ob_item_r;
  assign out_empty = !ob_valid_r;

endmodule

>>> rtl/huffman_code_table_bit_packer_core.sv
// Huffman code table and MSB-first bit packer, top level.
// Throughput: one input per cycle while in_full is low, into a 4-entry command queue;
// the packer outputs one byte per cycle while the output register is empty or popped.
// Reset (synchronous, active low) clears table valid bits, so every symbol reads as
// zero length, and empties accumulator, queue and output register; RAM is not swept.
module huffman_code_table_bit_packer_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  hctbp_pkg::in_item_t  in_item,
  output logic                 in_full,
  output logic                 out_empty,
  input  logic                 out_pop,
  output hctbp_pkg::out_item_t out_item
);

  logic            q_push;
  logic            q_full;
  logic            q_pop;
  logic            q_empty;
  hctbp_pkg::cmd_t q_din;
  hctbp_pkg::cmd_t q_dout;

  hctbp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_item (in_item),
    .in_full (in_full),
    .q_push  (q_push),
    .q_cmd   (q_din),
    .q_full  (q_full)
  );

  hctbp_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  hctbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_cmd     (q_dout),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_item  (out_item),
    .out_empty (out_empty),
    .out_pop   (out_pop)
  );

endmodule

>>> rtl/hctbp_checker.sv
// Port-level checker for the bit packer, bound to the top level.
module hctbp_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_full,
  input logic                 out_empty,
  input logic                 out_pop,
  input hctbp_pkg::out_item_t out_item
);

  a_reset_empties_output: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("output not empty after reset");

  a_reset_clears_full: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input full right after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("waiting result dropped");

  a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> $stable(out_item))
    else $error("waiting result changed");

endmodule

bind huffman_code_table_bit_packer_core hctbp_checker u_hctbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_item  (out_item)
);

>>> verif/huffman_code_table_bit_packer_core_test.sv
// Self-checking testbench for the Huffman code table and bit packer core.
module huffman_code_table_bit_packer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] KIND_RSVD = 2'd3;
  localparam int MAX_REPORTS = 10;

  logic                 clk;
  logic                 rst_n;
  logic                 in_push;
  hctbp_pkg::in_item_t  in_item;
  logic                 in_full;
  logic                 out_empty;
  logic                 out_pop;
  hctbp_pkg::out_item_t out_item;

  logic [hctbp_pkg::CODE_W-1:0]    code_tbl [hctbp_pkg::SYMBOL_COUNT];
  logic [hctbp_pkg::LEN_W-1:0]     len_tbl  [hctbp_pkg::SYMBOL_COUNT];
  logic [hctbp_pkg::RES_MAX_W-1:0] acc_bits;
  logic [hctbp_pkg::RES_W-1:0]     pend_cnt;

  hctbp_pkg::out_item_t        expected_bytes [$];
  logic [hctbp_pkg::SYM_W-1:0] loaded_syms [$];
  int                          mismatch_cnt;
  int                          send_idle;
  int                          recv_idle;
  int                          hold_req;

  huffman_code_table_bit_packer_core DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #500000;
    $display("FAIL huffman_code_table_bit_packer_core");
    $finish;
  end

  function automatic void clear_packer_model();
    for (int i = 0; i < hctbp_pkg::SYMBOL_COUNT; i++) begin
      code_tbl[i] = '0;
      len_tbl[i]  = '0;
    end
    acc_bits = '0;
    pend_cnt = '0;
  endfunction

  function automatic void pack_expected_bytes(input hctbp_pkg::in_item_t it);
    logic [63:0]                 acc64;
    int unsigned                 total;
    int unsigned                 clen;
    logic [hctbp_pkg::LEN_W-1:0] len;
    hctbp_pkg::out_item_t        r;
    case (it.kind)
      hctbp_pkg::KIND_LOAD: begin
        if (it.symbol < hctbp_pkg::SYMBOL_COUNT) begin
          len = it.code_length;
          if (len > hctbp_pkg::LEN_LIMIT) len = hctbp_pkg::LEN_W'(hctbp_pkg::LEN_LIMIT);
          code_tbl[it.symbol] = it.code_bits;
          len_tbl[it.symbol]  = len;
        end
      end
      hctbp_pkg::KIND_ENCODE: begin
        if (it.symbol < hctbp_pkg::SYMBOL_COUNT && len_tbl[it.symbol] != 0) begin
          clen  = len_tbl[it.symbol];
          acc64 = (64'(acc_bits) << clen) |
                  (64'(code_tbl[it.symbol]) & ((64'd1 << clen) - 64'd1));
          total = pend_cnt + clen;
          while (total >= 8) begin
            r.packed_byte = 8'(acc64 >> (total - 8));
            r.last_of_run = (total - 8 < 8);
            expected_bytes.push_back(r);
            total -= 8;
          end
          pend_cnt = hctbp_pkg::RES_W'(total);
          acc_bits = hctbp_pkg::RES_MAX_W'(acc64 & ((64'd1 << total) - 64'd1));
        end
      end
      hctbp_pkg::KIND_FLUSH: begin
        if (pend_cnt != 0) begin
          r.packed_byte = 8'(16'(acc_bits) << (8 - pend_cnt));
          r.last_of_run = 1'b1;
          expected_bytes.push_back(r);
          acc_bits = '0;
          pend_cnt = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void report_error(input string msg);
    if (mismatch_cnt < MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endfunction

  function automatic void check_byte(input hctbp_pkg::out_item_t got);
    hctbp_pkg::out_item_t want;
    if (expected_bytes.size() == 0) begin
      report_error($sformatf("unexpected byte %02h last %0b", got.packed_byte,
                             got.last_of_run));
      return;
    end
    want = expected_bytes.pop_front();
    if (got.packed_byte !== want.packed_byte)
      report_error($sformatf("packed_byte expected %02h got %02h", want.packed_byte,
                             got.packed_byte));
    if (got.last_of_run !== want.last_of_run)
      report_error($sformatf("last_of_run expected %0b got %0b", want.last_of_run,
                             got.last_of_run));
  endfunction

  // receiver: checks each popped transaction, stalls in bursts or on a hold request
  initial begin
    int stall_left;
    stall_left = 0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) check_byte(out_item);
      if (hold_req > 0) begin
        stall_left = hold_req;
        hold_req = 0;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (recv_idle != 0 && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  task automatic send_item(input hctbp_pkg::in_item_t it);
    if (send_idle != 0 && $urandom_range(0, 3) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_full);
    pack_expected_bytes(it);
  endtask

  function automatic hctbp_pkg::in_item_t make_item(input logic [1:0] kind,
                                                    input logic [7:0] sym,
                                                    input logic [31:0] bits,
                                                    input logic [5:0] len);
    hctbp_pkg::in_item_t it;
    it.kind        = hctbp_pkg::kind_t'(kind);
    it.symbol      = sym;
    it.code_bits   = bits;
    it.code_length = len;
    return it;
  endfunction

  task automatic load(input logic [7:0] sym, input logic [31:0] bits, input logic [5:0] len);
    send_item(make_item(hctbp_pkg::KIND_LOAD, sym, bits, len));
    loaded_syms.push_back(sym);
  endtask

  task automatic encode(input logic [7:0] sym);
    send_item(make_item(hctbp_pkg::KIND_ENCODE, sym, $urandom, 6'($urandom)));
  endtask

  task automatic flush();
    send_item(make_item(hctbp_pkg::KIND_FLUSH, 8'($urandom), $urandom, 6'($urandom)));
  endtask

  function automatic logic [5:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 6'd0;
    if (r <= 2) return 6'($urandom_range(33, 63));
    if (r <= 6) return 6'($urandom_range(24, 32));
    return 6'($urandom_range(1, 32));
  endfunction

  function automatic hctbp_pkg::in_item_t random_item();
    int unsigned r;
    logic [7:0]  sym;
    r = $urandom_range(0, 99);
    if (r < 15)
      return make_item(hctbp_pkg::KIND_LOAD, 8'($urandom), $urandom, pick_len());
    if (r < 82) begin
      sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
      return make_item(hctbp_pkg::KIND_ENCODE, sym, $urandom, 6'($urandom));
    end
    if (r < 90)
      return make_item(hctbp_pkg::KIND_FLUSH, 8'($urandom), $urandom, 6'($urandom));
    if (r < 95) return make_item(KIND_RSVD, 8'($urandom), $urandom, 6'($urandom));
    return make_item(hctbp_pkg::KIND_ENCODE, 8'($urandom), $urandom, 6'($urandom));
  endfunction

  task automatic send_random(input int count);
    hctbp_pkg::in_item_t it;
    for (int i = 0; i < count; i++) begin
      it = random_item();
      send_item(it);
      if (it.kind == hctbp_pkg::KIND_LOAD) loaded_syms.push_back(it.symbol);
    end
  endtask

  task automatic test_directed();
    encode(8'h00);                       // never loaded
    flush();                             // nothing pending
    send_item(make_item(KIND_RSVD, 8'hFF, 32'hFFFF_FFFF, 6'h3F));
    load(8'h00, 32'hFFFF_FFFF, 6'd32);
    load(8'hFF, 32'hFFFF_FFF5, 6'd3);    // upper code bits ignored
    load(8'h80, 32'hA5A5_A5A5, 6'd63);   // saturates to the limit
    load(8'h01, 32'h0000_0001, 6'd1);
    load(8'h02, 32'hFFFF_FFFF, 6'd0);    // loaded with zero length
    load(8'h7F, 32'h0000_0055, 6'd7);
    load(8'h03, 32'h0000_0000, 6'd32);
    encode(8'h01);
    encode(8'h7F);
    encode(8'h00);
    encode(8'hFF);
    encode(8'h02);
    encode(8'h80);
    flush();
    encode(8'h7F);
    encode(8'h00);
    encode(8'h03);
    flush();
    encode(8'h03);
    flush();
  endtask

  task automatic test_random_traffic();
    for (int i = 0; i < 12; i++) load(8'($urandom), $urandom, 6'($urandom_range(1, 32)));
    send_random(115);
  endtask

  task automatic test_backpressure();
    hold_req = 120;
    send_idle = 0;
    for (int i = 0; i < 30; i++) encode(loaded_syms[$urandom_range(0, loaded_syms.size() - 1)]);
    send_idle = 1;
  endtask

  task automatic test_no_idle_tail();
    send_idle = 0;
    recv_idle = 0;
    send_random(40);
    flush();
  endtask

  task automatic wait_drained();
    int waited;
    in_push <= 1'b0;
    waited = 0;
    while (expected_bytes.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (expected_bytes.size() != 0)
      report_error($sformatf("%0d expected bytes never arrived", expected_bytes.size()));
  endtask

  initial begin
    mismatch_cnt = 0;
    send_idle    = 1;
    recv_idle    = 1;
    hold_req     = 0;
    rst_n   <= 1'b0;
    in_push <= 1'b0;
    in_item <= '0;
    clear_packer_model();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_traffic();
    test_backpressure();
    test_no_idle_tail();
    wait_drained();
    if (mismatch_cnt == 0) begin
      $display("PASS huffman_code_table_bit_packer_core");
    end else begin
      $display("FAIL huffman_code_table_bit_packer_core");
    end
    $finish;
  end

endmodule
